>>> rtl/core/ffpa_pkg.sv
// Shared definitions for the first-fit partition allocator.
// Widths, function and result codes, and the controller/datapath structs.
// No dependencies.
package ffpa_pkg;

  // Table geometry.
  localparam int SLOTS     = 16;
  localparam int SIZE_BITS = 16;
  localparam int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int LIM_W     = IDX_W + 1;

  // Fixed field widths of the channels and the register.
  localparam int FUNC_W   = 1;
  localparam int SLOT_W   = 4;
  localparam int AMOUNT_W = 16;
  localparam int PIDX_W   = 4;
  localparam int CFG_W    = 5;

  // Compare widths that cover both operands.
  localparam int CFG_CMP_W  = (LIM_W > CFG_W) ? LIM_W : CFG_W;
  localparam int SLOT_CMP_W = (LIM_W > SLOT_W) ? LIM_W : SLOT_W;

  // Function codes.
  localparam logic [FUNC_W-1:0] FUNC_LOAD  = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 1'b1;

  // Result kinds loaded into the output register.
  localparam logic [1:0] RES_LOAD = 2'd0;
  localparam logic [1:0] RES_HIT  = 2'd1;
  localparam logic [1:0] RES_MISS = 2'd2;

  typedef struct packed {
    logic       load;        // write an input size into the table
    logic       start;       // latch the request and rewind the scan
    logic       step;        // issue the next table read
    logic       write_back;  // store reduced capacity of the compared slot
    logic       res_load;    // load the output register
    logic [1:0] res_kind;
  } ffpa_cmd_t;

  typedef struct packed {
    logic lim_zero;  // no slots take part in the search
    logic hit;       // compared slot fits the request
    logic last;      // compared slot is the last one in use
  } ffpa_stat_t;

endpackage

>>> rtl/core/ffpa_in_if.sv
// Input channel of the first-fit partition allocator: valid/ready plus item.
// Depends on ffpa_pkg.
interface ffpa_in_if;
  logic                            valid;
  logic                            ready;
  logic [ffpa_pkg::FUNC_W-1:0]     func;
  logic [ffpa_pkg::SLOT_W-1:0]     slot;
  logic [ffpa_pkg::AMOUNT_W-1:0]   amount;

  modport source (output valid, output func, output slot, output amount, input ready);
  modport sink   (input valid, input func, input slot, input amount, output ready);
endinterface

>>> rtl/core/ffpa_out_if.sv
// Result channel of the first-fit partition allocator: valid/ready plus item.
// Depends on ffpa_pkg.
interface ffpa_out_if;
  logic                          valid;
  logic                          ready;
  logic                          granted;
  logic [ffpa_pkg::PIDX_W-1:0]   partition_index;

  modport source (output valid, output granted, output partition_index, input ready);
  modport sink   (input valid, input granted, input partition_index, output ready);
endinterface

>>> rtl/core/first_fit_partition_allocator.sv
// Top level of the first-fit partition allocator: controller plus datapath.
// Depends on ffpa_pkg, ffpa_in_if, ffpa_out_if, ffpa_ctrl and ffpa_dp.
//
//   Port     Dir  Handshake     Content
//   in_ch    in   valid/ready   func, slot, amount
//   out_ch   out  valid/ready   granted, partition_index
//   cfg_*    in   cfg_we        partitions_in_use (cfg_wdata)
//
// A load item, and an allocate item under a count of zero, give their result in the
// cycle after acceptance. An allocate reads slots in ascending order up to the count
// (count clamped to the table size), one slot read a cycle, and stops at the first fit.
// Synchronous reset clears the per-slot valid bits at once; no clearing pass.
// One item is in work at a time; a new item is taken when the block is idle and
// the result register is empty or being emptied.
module first_fit_partition_allocator (
  input  logic                        clk,
  input  logic                        rst_n,
  ffpa_in_if.sink                     in_ch,
  ffpa_out_if.source                  out_ch,
  input  logic                        cfg_we,
  input  logic [ffpa_pkg::CFG_W-1:0]  cfg_wdata
);

  ffpa_pkg::ffpa_cmd_t  cmd;
  ffpa_pkg::ffpa_stat_t stat;

  ffpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_func   (in_ch.func),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ffpa_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_slot     (in_ch.slot),
    .in_amount   (in_ch.amount),
    .cmd         (cmd),
    .stat        (stat),
    .res_granted (out_ch.granted),
    .res_index   (out_ch.partition_index)
  );

endmodule

>>> rtl/core/ffpa_dp.sv
// Datapath of the first-fit partition allocator: capacity memory with valid
// bits, scan pointers, compare/subtract and the result register. Uses ffpa_pkg.
module ffpa_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [ffpa_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic [ffpa_pkg::SLOT_W-1:0]     in_slot,
  input  logic [ffpa_pkg::AMOUNT_W-1:0]   in_amount,
  input  ffpa_pkg::ffpa_cmd_t             cmd,
  output ffpa_pkg::ffpa_stat_t            stat,
  output logic                            res_granted,
  output logic [ffpa_pkg::PIDX_W-1:0]     res_index
);

  logic [ffpa_pkg::CFG_W-1:0]      cfg_r;
  logic [ffpa_pkg::SIZE_BITS-1:0]  cap_mem [ffpa_pkg::SLOTS];
  logic                            valid_r [ffpa_pkg::SLOTS];
  logic [ffpa_pkg::SIZE_BITS-1:0]  rd_data_r;
  logic                            rd_valid_r;
  logic [ffpa_pkg::SIZE_BITS-1:0]  amt_r;
  logic [ffpa_pkg::LIM_W-1:0]      lim_r;
  logic [ffpa_pkg::LIM_W-1:0]      issue_ptr_r;
  logic [ffpa_pkg::LIM_W-1:0]      cmp_ptr_r;
  logic                            cmp_live_r;
  logic                            granted_r;
  logic [ffpa_pkg::PIDX_W-1:0]     index_r;

  logic [ffpa_pkg::CFG_CMP_W-1:0]  cfg_ext;
  logic [ffpa_pkg::LIM_W-1:0]      lim_nxt;
  logic                            slot_ok;
  logic [ffpa_pkg::IDX_W-1:0]      ld_addr;
  logic [ffpa_pkg::IDX_W-1:0]      issue_addr;
  logic [ffpa_pkg::IDX_W-1:0]      cmp_addr;
  logic [ffpa_pkg::SIZE_BITS-1:0]  in_amt;
  logic [ffpa_pkg::SIZE_BITS-1:0]  cap_now;

  // Counts above the table size search the whole table.
  assign cfg_ext = ffpa_pkg::CFG_CMP_W'(cfg_r);
  assign lim_nxt = (cfg_ext > ffpa_pkg::CFG_CMP_W'(ffpa_pkg::SLOTS)) ?
                   ffpa_pkg::LIM_W'(ffpa_pkg::SLOTS) : ffpa_pkg::LIM_W'(cfg_ext);

  assign slot_ok    = ffpa_pkg::SLOT_CMP_W'(in_slot) < ffpa_pkg::SLOT_CMP_W'(ffpa_pkg::SLOTS);
  assign ld_addr    = ffpa_pkg::IDX_W'(in_slot);
  assign issue_addr = issue_ptr_r[ffpa_pkg::IDX_W-1:0];
  assign cmp_addr   = cmp_ptr_r[ffpa_pkg::IDX_W-1:0];
  assign in_amt     = ffpa_pkg::SIZE_BITS'(in_amount);

  // A slot never written since reset holds zero capacity.
  assign cap_now = rd_valid_r ? rd_data_r : '0;

  assign stat.lim_zero = (lim_nxt == '0);
  assign stat.hit      = cmp_live_r && (cap_now >= amt_r);
  assign stat.last     = cmp_live_r && ((cmp_ptr_r + ffpa_pkg::LIM_W'(1)) == lim_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      cfg_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ffpa_pkg::SLOTS; i++) begin
        valid_r[i] <= 1'b0;
      end
    end else if (cmd.load && slot_ok) begin
      valid_r[ld_addr] <= 1'b1;
    end else if (cmd.write_back) begin
      valid_r[cmp_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && slot_ok) begin
      cap_mem[ld_addr] <= in_amt;
    end else if (cmd.write_back) begin
      cap_mem[cmp_addr] <= cap_now - amt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      rd_data_r  <= cap_mem[issue_addr];
      rd_valid_r <= valid_r[issue_addr];
      cmp_ptr_r  <= issue_ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_ptr_r <= '0;
      cmp_live_r  <= 1'b0;
    end else if (cmd.start) begin
      issue_ptr_r <= '0;
      cmp_live_r  <= 1'b0;
    end else begin
      if (cmd.step) begin
        issue_ptr_r <= issue_ptr_r + ffpa_pkg::LIM_W'(1);
      end
      cmp_live_r <= cmd.step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      amt_r <= in_amt;
      lim_r <= lim_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      case (cmd.res_kind)
        ffpa_pkg::RES_LOAD: begin
          granted_r <= slot_ok;
          index_r   <= slot_ok ? ffpa_pkg::PIDX_W'(in_slot) : '0;
        end
        ffpa_pkg::RES_HIT: begin
          granted_r <= 1'b1;
          index_r   <= ffpa_pkg::PIDX_W'(cmp_ptr_r);
        end
        default: begin
          granted_r <= 1'b0;
          index_r   <= '0;
        end
      endcase
    end
  end

  assign res_granted = granted_r;
  assign res_index   = index_r;

endmodule

>>> rtl/core/ffpa_ctrl.sv
// Controller of the first-fit partition allocator: handshakes, scan
// sequencing and the result valid flag. Uses ffpa_pkg.
module ffpa_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic [ffpa_pkg::FUNC_W-1:0]  in_func,
  output logic                         in_ready,
  output logic                         out_valid,
  input  logic                         out_ready,
  input  ffpa_pkg::ffpa_stat_t         stat,
  output ffpa_pkg::ffpa_cmd_t          cmd
);

  localparam logic [0:0] ST_IDLE = 1'b0;
  localparam logic [0:0] ST_SCAN = 1'b1;

  logic [0:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;

  // The result register frees up in the same cycle it is taken.
  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_func == ffpa_pkg::FUNC_LOAD) begin
            cmd.load     = 1'b1;
            cmd.res_load = 1'b1;
            cmd.res_kind = ffpa_pkg::RES_LOAD;
          end else if (stat.lim_zero) begin
            cmd.res_load = 1'b1;
            cmd.res_kind = ffpa_pkg::RES_MISS;
          end else begin
            cmd.start = 1'b1;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.step = 1'b1;
        if (stat.hit) begin
          cmd.write_back = 1'b1;
          cmd.res_load   = 1'b1;
          cmd.res_kind   = ffpa_pkg::RES_HIT;
          state_nxt      = ST_IDLE;
        end else if (stat.last) begin
          cmd.res_load = 1'b1;
          cmd.res_kind = ffpa_pkg::RES_MISS;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> tb/sv/first_fit_partition_allocator_tb.sv
// Testbench for first_fit_partition_allocator: directed and random load and allocate items
// with random idling on both channels, checked against an in-bench capacity table model.
// Depends on ffpa_pkg, ffpa_in_if, ffpa_out_if and the allocator RTL.
`timescale 1ns / 100ps

module first_fit_partition_allocator_tb;

  typedef struct {
    logic                          granted;
    logic [ffpa_pkg::PIDX_W-1:0]   pidx;
    logic [ffpa_pkg::FUNC_W-1:0]   func;
    logic [ffpa_pkg::AMOUNT_W-1:0] amount;
  } grant_t;

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_we;
  logic [ffpa_pkg::CFG_W-1:0] cfg_wdata;

  ffpa_in_if  in_ch();
  ffpa_out_if out_ch();

  first_fit_partition_allocator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Model of the block: remaining capacity per slot and the search count.
  logic [ffpa_pkg::SIZE_BITS-1:0] capacity [ffpa_pkg::SLOTS];
  logic [ffpa_pkg::CFG_W-1:0]     part_count;

  grant_t pending_grants[$];
  int     mismatch_count;
  bit     no_idle;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 50) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Applies one item to the capacity model and returns the result it must produce.
  function automatic grant_t predict_grant(input logic [ffpa_pkg::FUNC_W-1:0] func,
                                           input logic [ffpa_pkg::SLOT_W-1:0] slot,
                                           input logic [ffpa_pkg::AMOUNT_W-1:0] amount);
    grant_t                         r;
    int                             search_len;
    logic [ffpa_pkg::SIZE_BITS-1:0] req;
    req       = ffpa_pkg::SIZE_BITS'(amount);
    r.func    = func;
    r.amount  = amount;
    r.granted = 1'b0;
    r.pidx    = '0;
    if (func == ffpa_pkg::FUNC_LOAD) begin
      if (int'(slot) < ffpa_pkg::SLOTS) begin
        capacity[slot] = req;
        r.granted      = 1'b1;
        r.pidx         = ffpa_pkg::PIDX_W'(slot);
      end
      return r;
    end
    search_len = (int'(part_count) > ffpa_pkg::SLOTS) ? ffpa_pkg::SLOTS : int'(part_count);
    for (int j = 0; j < search_len; j++) begin
      if (capacity[j] >= req) begin
        capacity[j] = capacity[j] - req;
        r.granted   = 1'b1;
        r.pidx      = ffpa_pkg::PIDX_W'(j);
        return r;
      end
    end
    return r;
  endfunction

  // Called at a rising edge; returns at the edge where the item is accepted,
  // with valid still high so that a following item can go back to back.
  task automatic send_item(input logic [ffpa_pkg::FUNC_W-1:0]   func,
                           input logic [ffpa_pkg::SLOT_W-1:0]   slot,
                           input logic [ffpa_pkg::AMOUNT_W-1:0] amount);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.func   <= func;
    in_ch.slot   <= slot;
    in_ch.amount <= amount;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    pending_grants.push_back(predict_grant(func, slot, amount));
  endtask

  // Every item gives one result, so an empty queue means the block is idle.
  task automatic wait_for_idle();
    in_ch.valid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
  endtask

  task automatic set_partition_count(input logic [ffpa_pkg::CFG_W-1:0] count);
    wait_for_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= count;
    @(posedge clk);
    cfg_we     <= 1'b0;
    part_count = count;
  endtask

  function automatic void draw_item(output logic [ffpa_pkg::FUNC_W-1:0]   func,
                                    output logic [ffpa_pkg::SLOT_W-1:0]   slot,
                                    output logic [ffpa_pkg::AMOUNT_W-1:0] amount);
    int unsigned span;
    int unsigned k;
    span = (int'(part_count) > ffpa_pkg::SLOTS) ? ffpa_pkg::SLOTS : int'(part_count);
    k    = (span > 0) ? $urandom_range(0, span - 1) : 0;
    slot = ffpa_pkg::SLOT_W'($urandom_range(0, ffpa_pkg::SLOTS - 1));
    if ($urandom_range(0, 99) < 35) begin
      func = ffpa_pkg::FUNC_LOAD;
      // Loads mostly land in the searched window so that allocations can hit.
      if (span > 0 && $urandom_range(0, 3) != 0) slot = ffpa_pkg::SLOT_W'(k);
      case ($urandom_range(0, 3))
        0:       amount = ffpa_pkg::AMOUNT_W'($urandom_range(0, 255));
        1:       amount = '1;
        default: amount = ffpa_pkg::AMOUNT_W'($urandom());
      endcase
    end else begin
      func = ffpa_pkg::FUNC_ALLOC;
      case ($urandom_range(0, 5))
        0:       amount = ffpa_pkg::AMOUNT_W'(capacity[k]);
        1:       amount = ffpa_pkg::AMOUNT_W'($urandom_range(0, capacity[k]));
        2:       amount = ffpa_pkg::AMOUNT_W'($urandom_range(0, 63));
        3:       amount = ffpa_pkg::AMOUNT_W'(capacity[k]) + 1'b1;
        4:       amount = $urandom_range(0, 1) ? '1 : '0;
        default: amount = ffpa_pkg::AMOUNT_W'($urandom());
      endcase
    end
  endfunction

  task automatic test_reset_state();
    // Count is zero out of reset, so nothing can be granted.
    send_item(ffpa_pkg::FUNC_ALLOC, '0, '0);
    send_item(ffpa_pkg::FUNC_ALLOC, '1, '1);
    // A count above the table size covers every slot; all are empty.
    set_partition_count(5'd31);
    send_item(ffpa_pkg::FUNC_ALLOC, '0, '0);
    send_item(ffpa_pkg::FUNC_ALLOC, '0, 16'd1);
  endtask

  task automatic test_first_fit_order();
    send_item(ffpa_pkg::FUNC_LOAD, 4'd0, 16'd10);
    send_item(ffpa_pkg::FUNC_LOAD, 4'd3, 16'd100);
    send_item(ffpa_pkg::FUNC_LOAD, 4'd15, '1);
    send_item(ffpa_pkg::FUNC_LOAD, 4'd7, '0);
    send_item(ffpa_pkg::FUNC_ALLOC, '0, '1);
    send_item(ffpa_pkg::FUNC_ALLOC, '1, 16'd100);
    send_item(ffpa_pkg::FUNC_ALLOC, '0, 16'd10);
    send_item(ffpa_pkg::FUNC_ALLOC, '0, '0);
    send_item(ffpa_pkg::FUNC_ALLOC, '0, 16'd1);
  endtask

  task automatic test_count_window();
    send_item(ffpa_pkg::FUNC_LOAD, 4'd0, 16'd5);
    send_item(ffpa_pkg::FUNC_LOAD, 4'd15, '1);
    set_partition_count(5'd1);
    send_item(ffpa_pkg::FUNC_ALLOC, '0, 16'd6);
    send_item(ffpa_pkg::FUNC_ALLOC, '0, 16'd5);
    set_partition_count(5'd15);
    send_item(ffpa_pkg::FUNC_ALLOC, '0, 16'd1);
    set_partition_count(5'd16);
    send_item(ffpa_pkg::FUNC_ALLOC, '0, 16'd1);
  endtask

  task automatic test_random_traffic();
    logic [ffpa_pkg::FUNC_W-1:0]   func;
    logic [ffpa_pkg::SLOT_W-1:0]   slot;
    logic [ffpa_pkg::AMOUNT_W-1:0] amount;
    logic [ffpa_pkg::CFG_W-1:0]    count;
    int                            pause_at;
    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0:       count = 5'd16;
        1:       count = 5'd31;
        2:       count = 5'd1;
        3:       count = 5'd17;
        4:       count = 5'd0;
        default: count = ($urandom_range(0, 3) == 0) ?
                         ffpa_pkg::CFG_W'($urandom_range(0, 31)) :
                         ffpa_pkg::CFG_W'($urandom_range(2, 16));
      endcase
      set_partition_count(count);
      no_idle  = (phase % 4 == 2);
      pause_at = $urandom_range(5, 35);
      for (int n = 0; n < 40; n++) begin
        if (n == pause_at) wait_for_idle();
        draw_item(func, slot, amount);
        send_item(func, slot, amount);
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    in_ch.valid  <= 1'b0;
    in_ch.func   <= ffpa_pkg::FUNC_LOAD;
    in_ch.slot   <= '0;
    in_ch.amount <= '0;
    cfg_we       <= 1'b0;
    cfg_wdata    <= '0;
    rst_n        <= 1'b0;
    no_idle        = 1'b0;
    mismatch_count = 0;
    part_count     = '0;
    foreach (capacity[i]) capacity[i] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_first_fit_order();
    test_count_window();
    test_random_traffic();

    wait_for_idle();
    repeat (25) @(posedge clk);
    if (mismatch_count == 0 && pending_grants.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Result side: random stall before raising ready, then one item is taken and checked.
  initial begin : result_checker
    int unsigned stall;
    grant_t      want;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (out_ch.valid !== 1'b1) @(posedge clk);
      if (pending_grants.size() == 0) begin
        report_mismatch($sformatf("unexpected result granted=%0b index=%0d",
                                  out_ch.granted, out_ch.partition_index));
      end else begin
        want = pending_grants.pop_front();
        if (out_ch.granted !== want.granted)
          report_mismatch($sformatf("%s amount %0d: granted %0b, expected %0b",
                                    (want.func == ffpa_pkg::FUNC_LOAD) ? "load" : "alloc",
                                    want.amount, out_ch.granted, want.granted));
        if (out_ch.partition_index !== want.pidx)
          report_mismatch($sformatf("%s amount %0d: index %0d, expected %0d",
                                    (want.func == ffpa_pkg::FUNC_LOAD) ? "load" : "alloc",
                                    want.amount, out_ch.partition_index, want.pidx));
      end
    end
  end

  initial begin
    #(5_000_000);
    $display("Verification failed");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/ffpa_pkg.sv
rtl/core/ffpa_in_if.sv
rtl/core/ffpa_out_if.sv
rtl/core/ffpa_dp.sv
rtl/core/ffpa_ctrl.sv
rtl/core/first_fit_partition_allocator.sv
tb/sv/first_fit_partition_allocator_tb.sv
